// File: rtl/bmc_pkg.sv
// shared types and constants for the button multitap classifier
// no dependencies; imported by every module of the block
`default_nettype none

package bmc_pkg;

  // button phase codes, the unused code 7 behaves as idle
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN1 = 3'd1,
    PH_LONG  = 3'd2,
    PH_UP1   = 3'd3,
    PH_DOWN2 = 3'd4,
    PH_UP2   = 3'd5,
    PH_DOWN3 = 3'd6
  } phase_t;

  // event kinds reported on the result channel
  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_TRIPLE = 2'd3
  } ev_kind_t;

  // scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } scan_state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [1:0] CFG_GAP        = 2'd1;
  localparam logic [1:0] CFG_ACTIVE     = 2'd2;

  localparam int TICK_W   = 32;
  localparam int IDX_OUT_W = 5;
  localparam int ACTIVE_W = 6;

  // contents of one cell of the ring: per-button state plus its mask bit
  typedef struct packed {
    phase_t              phase;
    logic [TICK_W-1:0]   edge_tick;
    logic                down;
  } cell_t;

endpackage

`default_nettype wire

// File: rtl/bmc_cell.sv
// one ring cell: holds the phase, edge tick and mask bit of one button
// depends on bmc_pkg
`default_nettype none

module bmc_cell
  import bmc_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   load_en,
  input  wire   mask_bit,
  input  wire   shift_en,
  input  cell_t d,
  output cell_t q
);

  cell_t q_r;

  // mask bit is loaded per word, the whole cell shifts during a scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.phase     <= PH_IDLE;
      q_r.edge_tick <= '0;
      q_r.down      <= 1'b0;
    end else if (load_en) begin
      q_r.down <= mask_bit;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: rtl/bmc_update.sv
// per-button phase machine applied to the cell at the head of the ring
// depends on bmc_pkg
`default_nettype none

module bmc_update
  import bmc_pkg::*;
(
  input  cell_t             cur,
  input  wire  [TICK_W-1:0] now,
  input  wire  [TICK_W-1:0] long_ticks,
  input  wire  [TICK_W-1:0] gap_ticks,
  output cell_t             nxt,
  output logic              ev_valid,
  output ev_kind_t          ev_kind
);

  logic [TICK_W-1:0] elapsed;
  logic              hit_long;
  logic              hit_gap;

  // wrapping elapsed time since the last edge
  assign elapsed  = now - cur.edge_tick;
  assign hit_long = (elapsed == long_ticks);
  assign hit_gap  = (elapsed == gap_ticks);

  // phase transitions
  always_comb begin
    nxt      = cur;
    ev_valid = 1'b0;
    ev_kind  = EV_SHORT;
    case (cur.phase)
      PH_DOWN1: begin
        if (hit_long) begin
          nxt.phase = PH_LONG;
        end else if (!cur.down) begin
          nxt.phase     = PH_UP1;
          nxt.edge_tick = now;
        end
      end
      PH_LONG: begin
        if (!cur.down) begin
          nxt.phase = PH_IDLE;
          ev_valid  = 1'b1;
          ev_kind   = EV_LONG;
        end
      end
      PH_UP1: begin
        if (hit_gap) begin
          nxt.phase = PH_IDLE;
          ev_valid  = 1'b1;
          ev_kind   = EV_SHORT;
        end else if (cur.down) begin
          nxt.phase     = PH_DOWN2;
          nxt.edge_tick = now;
        end
      end
      PH_DOWN2: begin
        if (!cur.down) begin
          nxt.phase     = PH_UP2;
          nxt.edge_tick = now;
        end
      end
      PH_UP2: begin
        if (hit_gap) begin
          nxt.phase = PH_IDLE;
          ev_valid  = 1'b1;
          ev_kind   = EV_DOUBLE;
        end else if (cur.down) begin
          nxt.phase     = PH_DOWN3;
          nxt.edge_tick = now;
        end
      end
      PH_DOWN3: begin
        if (!cur.down) begin
          nxt.phase = PH_IDLE;
          ev_valid  = 1'b1;
          ev_kind   = EV_TRIPLE;
        end
      end
      default: begin
        // idle up, and the unused code
        if (cur.down) begin
          nxt.phase     = PH_DOWN1;
          nxt.edge_tick = now;
        end else begin
          nxt.phase = PH_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/button_multitap_classifier_top.sv
// top level of the button multitap classifier: ring of button cells,
// scan sequencer, pending event and output register
// depends on bmc_pkg, bmc_cell, bmc_update
//
// usage
//   in channel: one word per tick, in_tdata is the pressed mask, bit i for
//   button i. out channel: one word per event, in button order; out_tlast
//   marks the last event of a tick. a tick with no event gives no word.
//   cfg port: write enable, index and data; 0 long press ticks, 1 multitap
//   gap ticks, 2 active buttons (clipped to MAX_BUTTONS). write while idle.
// timing
//   the button states sit in a ring of MAX_BUTTONS cells that rotates one
//   place per cycle while not stalled past a single update unit; a tick is
//   accepted in idle, scanned over all MAX_BUTTONS cells, then flushed. one
//   tick is in the block at a time; in_tready is high only between ticks.
//   the first event of a tick appears after the scan has found a second
//   event or reached the end of the ring.
// reset and stalls
//   rst_n (synchronous, active low) clears the tick counter, all phases and
//   edge ticks and restores the register defaults. when out_tready is low
//   the finished word holds, the next event waits in the pending register
//   and the ring stops rotating at any further event until the word leaves.
`default_nettype none

module button_multitap_classifier_top
  import bmc_pkg::*;
#(
  parameter int MAX_BUTTONS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  // input words
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [31:0]        in_tdata,   // [31:0] pressed_mask
  // result words
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [7:0]         out_tdata,  // [4:0] button_index, [6:5] event_kind, [7] zero
  output logic               out_tlast,  // last_of_tick
  // configuration writes
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_addr,
  input  wire  [31:0]        cfg_wdata
);

  localparam int STEP_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [ACTIVE_W-1:0] MAX_CNT = ACTIVE_W'(MAX_BUTTONS);
  localparam logic [STEP_W-1:0]   LAST_STEP = STEP_W'(MAX_BUTTONS - 1);

  // configuration registers
  logic [TICK_W-1:0]   long_ticks_r;
  logic [TICK_W-1:0]   gap_ticks_r;
  logic [ACTIVE_W-1:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= TICK_W'(50);
      gap_ticks_r  <= TICK_W'(25);
      active_r     <= ACTIVE_W'(8);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LONG_PRESS: long_ticks_r <= cfg_wdata;
        CFG_GAP:        gap_ticks_r  <= cfg_wdata;
        CFG_ACTIVE:     active_r     <= cfg_wdata[ACTIVE_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer state and control
  scan_state_t         state_r, state_nxt;
  logic [TICK_W-1:0]   tick_r;
  logic [STEP_W-1:0]   step_r;
  logic [ACTIVE_W-1:0] count_r;
  logic                accept;
  logic                scanning;
  logic                flushing;
  logic                out_free;
  logic                advance;
  logic                head_active;
  logic                head_ev;

  // ring of cells
  cell_t cell_q [MAX_BUTTONS];
  cell_t upd_cell;
  cell_t head_nxt;
  logic  upd_ev_valid;
  ev_kind_t upd_ev_kind;

  // pending event and output register
  logic                 pend_v_r;
  logic [IDX_OUT_W-1:0] pend_idx_r;
  ev_kind_t             pend_kind_r;
  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  ev_kind_t             out_kind_r;
  logic                 out_last_r;
  logic                 out_load;
  logic                 out_load_last;

  assign out_free = !out_valid_r || out_tready;

  // control outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    scanning  = 1'b0;
    flushing  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SCAN:  scanning  = 1'b1;
      ST_FLUSH: flushing  = 1'b1;
      default:  ;
    endcase
  end

  assign accept      = in_tvalid && in_tready;
  assign head_active = ({{(ACTIVE_W-STEP_W){1'b0}}, step_r} < count_r);
  assign head_ev     = head_active && upd_ev_valid;
  // ring stops only when an event would overflow the pending register
  assign advance     = scanning && !(head_ev && pend_v_r && !out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (advance && step_r == LAST_STEP) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      step_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        tick_r  <= tick_r + TICK_W'(1);
        step_r  <= '0;
        count_r <= (active_r > MAX_CNT) ? MAX_CNT : active_r;
      end else if (advance) begin
        step_r  <= step_r + STEP_W'(1);
      end
    end
  end

  // shared update unit at the head of the ring
  bmc_update u_update (
    .cur        (cell_q[0]),
    .now        (tick_r),
    .long_ticks (long_ticks_r),
    .gap_ticks  (gap_ticks_r),
    .nxt        (upd_cell),
    .ev_valid   (upd_ev_valid),
    .ev_kind    (upd_ev_kind)
  );

  // unscanned buttons pass round the ring unchanged
  assign head_nxt = head_active ? upd_cell : cell_q[0];

  // cell i takes from cell i+1, the tail takes the updated head
  for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_cell
    cell_t d_in;
    if (i == MAX_BUTTONS - 1) begin : g_tail
      assign d_in = head_nxt;
    end else begin : g_mid
      assign d_in = cell_q[i+1];
    end
    bmc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load_en  (accept),
      .mask_bit (in_tdata[i]),
      .shift_en (advance),
      .d        (d_in),
      .q        (cell_q[i])
    );
  end

  // output register load: a new event pushes the pending one out,
  // the flush sends the pending one as last of the tick
  assign out_load_last = flushing && pend_v_r && out_free;
  assign out_load      = (advance && head_ev && pend_v_r) || out_load_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (advance && head_ev) begin
      pend_v_r <= 1'b1;
    end else if (out_load_last) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_ev) begin
      pend_idx_r  <= IDX_OUT_W'(step_r);
      pend_kind_r <= upd_ev_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r  <= pend_idx_r;
      out_kind_r <= pend_kind_r;
      out_last_r <= out_load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_kind_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: tb/bmc_event_checker.sv
// checker for the button multitap classifier: follows register writes and accepted
// tick words, predicts the event words and compares them with the result channel
// depends on bmc_pkg
module bmc_event_checker
  import bmc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] pressed_mask
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [7:0]  out_tdata,  // [4:0] button_index, [6:5] event_kind, [7] zero
  input  wire         out_tlast,  // last_of_tick
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [31:0] cfg_wdata,
  output int          pending_words,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted event word
  typedef struct packed {
    logic [4:0] btn;
    ev_kind_t   kind;
    logic       last;
  } tap_event_t;

  // own copy of the registers and the per-button stores
  logic [31:0] hold_limit;
  logic [31:0] gap_limit;
  logic [5:0]  scan_count;
  logic [31:0] tick_now;
  phase_t      phase_mem [32];
  logic [31:0] edge_mem [32];

  tap_event_t  event_q [$];
  int          errs = 0;

  // count a failure and report it
  task automatic flag_mismatch(input string field, input int want, input int got);
    errs++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  // one tick: advance the counter, then walk the scanned buttons in order
  task automatic classify_tick(input logic [31:0] mask);
    int          scan;
    int          n_new;
    logic [31:0] elapsed;
    logic        down;
    logic        fired;
    ev_kind_t    kind;
    scan = (scan_count > 6'd32) ? 32 : int'(scan_count);
    n_new = 0;
    tick_now = tick_now + 32'd1;
    for (int b = 0; b < scan; b++) begin
      elapsed = tick_now - edge_mem[b];
      down = mask[b];
      fired = 1'b0;
      kind = EV_SHORT;
      case (phase_mem[b])
        PH_DOWN1: begin
          if (elapsed == hold_limit) begin
            phase_mem[b] = PH_LONG;
          end else if (!down) begin
            phase_mem[b] = PH_UP1;
            edge_mem[b] = tick_now;
          end
        end
        PH_LONG: begin
          if (!down) begin
            phase_mem[b] = PH_IDLE;
            kind = EV_LONG;
            fired = 1'b1;
          end
        end
        PH_UP1: begin
          if (elapsed == gap_limit) begin
            phase_mem[b] = PH_IDLE;
            kind = EV_SHORT;
            fired = 1'b1;
          end else if (down) begin
            phase_mem[b] = PH_DOWN2;
            edge_mem[b] = tick_now;
          end
        end
        PH_DOWN2: begin
          if (!down) begin
            phase_mem[b] = PH_UP2;
            edge_mem[b] = tick_now;
          end
        end
        PH_UP2: begin
          if (elapsed == gap_limit) begin
            phase_mem[b] = PH_IDLE;
            kind = EV_DOUBLE;
            fired = 1'b1;
          end else if (down) begin
            phase_mem[b] = PH_DOWN3;
            edge_mem[b] = tick_now;
          end
        end
        PH_DOWN3: begin
          if (!down) begin
            phase_mem[b] = PH_IDLE;
            kind = EV_TRIPLE;
            fired = 1'b1;
          end
        end
        // idle, and the unused code behaves the same
        default: begin
          if (down) begin
            phase_mem[b] = PH_DOWN1;
            edge_mem[b] = tick_now;
          end else begin
            phase_mem[b] = PH_IDLE;
          end
        end
      endcase
      if (fired) begin
        event_q.push_back('{btn: 5'(b), kind: kind, last: 1'b0});
        n_new++;
      end
    end
    // last event of the tick carries the flag
    if (n_new > 0) event_q[event_q.size() - 1].last = 1'b1;
  endtask

  // compare one result word with the oldest prediction
  task automatic check_word();
    tap_event_t want;
    if (event_q.size() == 0) begin
      errs++;
      $error("result word with nothing expected: button_index %0d event_kind %0d last %0b",
             out_tdata[4:0], out_tdata[6:5], out_tlast);
    end else begin
      want = event_q.pop_front();
      if (out_tdata[4:0] !== want.btn)
        flag_mismatch("button_index", want.btn, out_tdata[4:0]);
      if (out_tdata[6:5] !== want.kind)
        flag_mismatch("event_kind", want.kind, out_tdata[6:5]);
      if (out_tlast !== want.last)
        flag_mismatch("last_of_tick", want.last, out_tlast);
    end
  endtask

  // watch the three ports at every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_limit = 32'd50;
      gap_limit = 32'd25;
      scan_count = 6'd8;
      tick_now = '0;
      for (int b = 0; b < 32; b++) begin
        phase_mem[b] = PH_IDLE;
        edge_mem[b] = '0;
      end
      event_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_word();
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LONG_PRESS: hold_limit = cfg_wdata;
          CFG_GAP:        gap_limit = cfg_wdata;
          CFG_ACTIVE:     scan_count = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) classify_tick(in_tdata);
    end
    pending_words <= event_q.size();
    fail_count <= errs;
  end

endmodule

// File: tb/button_multitap_classifier_top_tb.sv
// testbench top for the button multitap classifier: clock, reset, tick stimulus,
// register phases, result back-pressure and the verdict
// depends on bmc_pkg, button_multitap_classifier_top and bmc_event_checker
module button_multitap_classifier_top_tb
  import bmc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_NONE      = 2'd3;   // no register behind this index
  localparam int         SETTLE_CYCLES = 40;     // one full scan plus margin
  localparam int         CYCLE_LIMIT   = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_LONG_PRESS;
  logic [31:0] cfg_wdata = '0;
  int          pending_words;
  int          fail_count;

  // per-button level and remaining run length for the mask generator
  logic [31:0] held = '0;
  int unsigned run_left [32];

  int unsigned ready_left = 0;
  int unsigned cycles = 0;

  // directed ticks: reset defaults first, then short, long, double and triple
  // taps spread over the buttons, a tick with all 32 long presses released, and odd masks
  logic [31:0] tap_script [24] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'h2222_2222, 32'hEEEE_EEEE, 32'h2222_2222, 32'h8888_8888,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h8000_0001, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };

  button_multitap_classifier_top dut (.*);

  bmc_event_checker chk (.*);

  always #6 clk = ~clk;

  // result side back-pressure: short stalls, a few long ones, long ready stretches
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
      ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 12);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_multitap_classifier_top verification failed");
      $finish;
    end
  end

  // offer one tick word after a random gap and wait for it to be taken
  task automatic send_tick(input logic [31:0] mask);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= mask;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off the sender until every predicted event has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // registers change only once the block has gone quiet
  task automatic set_config(input logic [31:0] hold, input logic [31:0] gap,
                            input logic [5:0] active);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_NONE, $urandom);
    write_reg(CFG_LONG_PRESS, hold);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_ACTIVE, {26'($urandom), active});
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed press and release runs per button, some plain noise
  task automatic next_mask(input int unsigned span, output logic [31:0] mask);
    if ($urandom_range(0, 9) == 0) begin
      mask = $urandom;
    end else begin
      for (int b = 0; b < 32; b++) begin
        if (run_left[b] == 0) begin
          held[b] = ~held[b];
          run_left[b] = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2 * span)
                                                   : $urandom_range(1, span);
        end else begin
          run_left[b]--;
        end
      end
      mask = held;
    end
  endtask

  // one register setting followed by random ticks sized to its thresholds
  task automatic run_phase(input logic [31:0] hold, input logic [31:0] gap,
                           input logic [5:0] active, input int n_items);
    int unsigned span;
    logic [31:0] mask;
    set_config(hold, gap, active);
    span = (hold > gap) ? ((hold > 32'd11) ? 11 : hold) : ((gap > 32'd11) ? 11 : gap);
    span = span + 2;
    repeat (n_items) begin
      if ($urandom_range(0, 39) == 0) drain();
      next_mask(span, mask);
      send_tick(mask);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: only the low eight buttons are scanned
    for (int i = 0; i < 3; i++) send_tick(tap_script[i]);

    // directed patterns with tight thresholds and every button scanned
    set_config(32'd3, 32'd2, 6'd32);
    for (int i = 3; i < 24; i++) send_tick(tap_script[i]);

    // random phases, extremes of every register among them
    run_phase(32'd3, 32'd2, 6'd32, 50);
    run_phase(32'd0, 32'd1, 6'd63, 40);
    run_phase(32'd1, 32'd0, 6'd32, 30);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd17, 30);
    run_phase(32'd6, 32'd5, 6'd0, 10);
    run_phase(32'd5, 32'd3, 6'd1, 30);
    repeat (3) begin
      run_phase($urandom_range(1, 10), $urandom_range(1, 8), 6'($urandom_range(1, 32)), 40);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("button_multitap_classifier_top verification clean");
    end else begin
      $display("button_multitap_classifier_top verification failed");
    end
    $finish;
  end

endmodule
